>>> rtl/core/mmg_pkg.sv
`timescale 1ns / 1ps
// Package for the matrix multiply with gradient block.
// Holds request codes, register indexes, accumulator width and the MAC control struct.
package mmg_pkg;

  localparam int ACC_W = 72;

  localparam logic [1:0] CFG_ROWS  = 2'd0;
  localparam logic [1:0] CFG_INNER = 2'd1;
  localparam logic [1:0] CFG_COLS  = 2'd2;

  typedef enum logic [2:0] {
    ACT_WR_A   = 3'd0,
    ACT_WR_B   = 3'd1,
    ACT_WR_G   = 3'd2,
    ACT_FWD    = 3'd3,
    ACT_BWD    = 3'd4,
    ACT_RD_C   = 3'd5,
    ACT_RD_DA  = 3'd6,
    ACT_RD_DB  = 3'd7
  } action_t;

  typedef struct packed {
    logic clr;
    logic mul;
    logic acc;
  } mac_ctl_t;

endpackage

>>> rtl/core/mmg_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces for the matrix block.
// Valid/ready handshake with the payload fields; no package dependency.
interface mmg_req_if;
  logic              valid;
  logic              ready;
  logic [2:0]        action;
  logic [2:0]        row;
  logic [2:0]        col;
  logic signed [31:0] element_value;
  modport source (output valid, action, row, col, element_value, input ready);
  modport sink (input valid, action, row, col, element_value, output ready);
endinterface

interface mmg_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  logic               index_error;
  modport source (output valid, read_value, index_error, input ready);
  modport sink (input valid, read_value, index_error, output ready);
endinterface

>>> rtl/core/mmg_mac.sv
`timescale 1ns / 1ps
// Shared multiply-accumulate unit with round-to-nearest and saturation.
// Depends on mmg_pkg for the control struct and accumulator width.
module mmg_mac import mmg_pkg::*; (
  input  logic               clk,
  input  mac_ctl_t           ctl,
  input  logic signed [31:0] init,
  input  logic signed [31:0] op_a,
  input  logic signed [31:0] op_b,
  output logic signed [31:0] result
);

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2147483647);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  logic signed [63:0]      prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] rnd;
  logic signed [ACC_W-1:0] sh;

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod <= op_a * op_b;
    end
    if (ctl.clr) begin
      acc <= ACC_W'(init) <<< 16;
    end else if (ctl.acc) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  always_comb begin
    rnd = acc + ACC_W'(32768);
    sh  = rnd >>> 16;
    if (sh > SAT_HI) begin
      result = 32'sh7fffffff;
    end else if (sh < SAT_LO) begin
      result = 32'sh80000000;
    end else begin
      result = sh[31:0];
    end
  end

endmodule

>>> rtl/core/matrix_multiply_with_gradient_top.sv
`timescale 1ns / 1ps
// Top level: six element memories, sequencer and the shared MAC.
// Writes answer in the cycle after the request; reads answer from the S_RD state.
// Forward: computes the product, then clears dA and dB.
// Backward: computes dA, then dB, on one shared multiplier; each MAC steps S_ISSUE, S_MUL, S_ACC.
// After reset a sweep over every memory entry zeroes the memories; no request is taken meanwhile.
module matrix_multiply_with_gradient_top import mmg_pkg::*; #(
  parameter int MAX_DIM = 8
) (
  input  logic       clk,
  input  logic       rst,
  mmg_req_if.sink    req,
  mmg_rsp_if.source  rsp,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [3:0] cfg_data
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(MAX_DIM);
  localparam int DW    = $clog2(MAX_DIM + 1);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_RD, S_ISSUE, S_MUL, S_ACC, S_WB, S_ZERO
  } state_t;

  typedef enum logic [1:0] {PH_FWD, PH_DA, PH_DB} phase_t;

  function automatic logic [DW-1:0] eff(input logic [3:0] r);
    if (r == 4'd0) begin
      return DW'(1);
    end else if (int'(r) > MAX_DIM) begin
      return DW'(MAX_DIM);
    end else begin
      return DW'(r);
    end
  endfunction

  function automatic logic [AW-1:0] addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(r) * AW'(MAX_DIM) + AW'(c);
  endfunction

  logic [3:0] rows_a;
  logic [3:0] inner_dim;
  logic [3:0] cols_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= 4'd8;
      inner_dim <= 4'd8;
      cols_b    <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROWS:  rows_a    <= cfg_data;
        CFG_INNER: inner_dim <= cfg_data;
        CFG_COLS:  cols_b    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [DW-1:0] dim_n, dim_m, dim_l;
  assign dim_n = eff(rows_a);
  assign dim_m = eff(inner_dim);
  assign dim_l = eff(cols_b);

  state_t           state;
  phase_t           phase;
  logic [IW-1:0]    x, y, z;
  logic [AW-1:0]    cnt;
  action_t          act;
  logic             err_q;
  logic             rsp_valid;
  logic signed [31:0] rsp_value;
  logic             rsp_err;

  // request decode
  action_t       req_act;
  logic [DW-1:0] rlim, clim;
  logic          req_err;
  logic          accept;
  logic          wr_accept;
  logic [AW-1:0] req_addr;

  assign req_act  = action_t'(req.action);
  assign req.ready = (state == S_IDLE) && (!rsp_valid || rsp.ready);
  assign accept   = req.valid && req.ready;
  assign wr_accept = accept &&
                     (req_act == ACT_WR_A || req_act == ACT_WR_B || req_act == ACT_WR_G);
  assign req_addr = addr(IW'(req.row), IW'(req.col));

  always_comb begin
    case (req_act)
      ACT_WR_A, ACT_RD_DA: begin rlim = dim_n; clim = dim_m; end
      ACT_WR_B, ACT_RD_DB: begin rlim = dim_m; clim = dim_l; end
      ACT_WR_G, ACT_RD_C:  begin rlim = dim_n; clim = dim_l; end
      default:             begin rlim = DW'(MAX_DIM); clim = DW'(MAX_DIM); end
    endcase
    req_err = (int'(req.row) >= int'(rlim)) || (int'(req.col) >= int'(clim));
    if (req_act == ACT_FWD || req_act == ACT_BWD) begin
      req_err = 1'b0;
    end
  end

  // loop limits per phase
  logic [DW-1:0] lim_x, lim_y, lim_z;
  always_comb begin
    case (phase)
      PH_FWD:  begin lim_x = dim_n; lim_y = dim_l; lim_z = dim_m; end
      PH_DA:   begin lim_x = dim_n; lim_y = dim_m; lim_z = dim_l; end
      PH_DB:   begin lim_x = dim_m; lim_y = dim_l; lim_z = dim_n; end
      default: begin lim_x = dim_n; lim_y = dim_l; lim_z = dim_m; end
    endcase
  end

  logic x_last, y_last, z_last, cnt_last;
  assign x_last   = (DW'(x) + DW'(1)) == lim_x;
  assign y_last   = (DW'(y) + DW'(1)) == lim_y;
  assign z_last   = (DW'(z) + DW'(1)) == lim_z;
  assign cnt_last = cnt == AW'(DEPTH - 1);

  // memories
  logic signed [31:0] mem_a  [DEPTH];
  logic signed [31:0] mem_b  [DEPTH];
  logic signed [31:0] mem_g  [DEPTH];
  logic signed [31:0] mem_c  [DEPTH];
  logic signed [31:0] mem_da [DEPTH];
  logic signed [31:0] mem_db [DEPTH];
  logic signed [31:0] rd_a, rd_b, rd_g, rd_c, rd_da, rd_db;
  logic [AW-1:0] ra_a, ra_b, ra_g, ra_xy;
  logic signed [31:0] mac_result;
  logic clearing, zeroing, wb;

  assign clearing = state == S_CLR;
  assign zeroing  = clearing || state == S_ZERO;
  assign wb       = state == S_WB;
  assign ra_xy    = (state == S_IDLE) ? req_addr : addr(x, y);

  always_comb begin
    ra_a = req_addr;
    ra_b = req_addr;
    ra_g = req_addr;
    if (state != S_IDLE) begin
      case (phase)
        PH_FWD: begin ra_a = addr(x, z); ra_b = addr(z, y); end
        PH_DA:  begin ra_g = addr(x, z); ra_b = addr(y, z); end
        PH_DB:  begin ra_a = addr(z, x); ra_g = addr(z, y); end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (clearing || (accept && req_act == ACT_WR_A && !req_err)) begin
      mem_a[clearing ? cnt : req_addr] <= clearing ? 32'sd0 : req.element_value;
    end
    rd_a <= mem_a[ra_a];
  end

  always_ff @(posedge clk) begin
    if (clearing || (accept && req_act == ACT_WR_B && !req_err)) begin
      mem_b[clearing ? cnt : req_addr] <= clearing ? 32'sd0 : req.element_value;
    end
    rd_b <= mem_b[ra_b];
  end

  always_ff @(posedge clk) begin
    if (clearing || (accept && req_act == ACT_WR_G && !req_err)) begin
      mem_g[clearing ? cnt : req_addr] <= clearing ? 32'sd0 : req.element_value;
    end
    rd_g <= mem_g[ra_g];
  end

  always_ff @(posedge clk) begin
    if (clearing || (wb && phase == PH_FWD)) begin
      mem_c[clearing ? cnt : ra_xy] <= clearing ? 32'sd0 : mac_result;
    end
    rd_c <= mem_c[ra_xy];
  end

  always_ff @(posedge clk) begin
    if (zeroing || (wb && phase == PH_DA)) begin
      mem_da[zeroing ? cnt : ra_xy] <= zeroing ? 32'sd0 : mac_result;
    end
    rd_da <= mem_da[ra_xy];
  end

  always_ff @(posedge clk) begin
    if (zeroing || (wb && phase == PH_DB)) begin
      mem_db[zeroing ? cnt : ra_xy] <= zeroing ? 32'sd0 : mac_result;
    end
    rd_db <= mem_db[ra_xy];
  end

  // shared MAC
  mac_ctl_t           mac_ctl;
  logic signed [31:0] op_a, op_b, mac_init;

  assign mac_ctl.clr = (state == S_MUL) && (z == IW'(0));
  assign mac_ctl.mul = state == S_MUL;
  assign mac_ctl.acc = state == S_ACC;

  always_comb begin
    case (phase)
      PH_DA:   begin op_a = rd_g; op_b = rd_b; mac_init = rd_da; end
      PH_DB:   begin op_a = rd_a; op_b = rd_g; mac_init = rd_db; end
      default: begin op_a = rd_a; op_b = rd_b; mac_init = 32'sd0; end
    endcase
  end

  mmg_mac u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .init   (mac_init),
    .op_a   (op_a),
    .op_b   (op_b),
    .result (mac_result)
  );

  logic signed [31:0] rd_sel;
  always_comb begin
    case (act)
      ACT_RD_C:  rd_sel = rd_c;
      ACT_RD_DA: rd_sel = rd_da;
      ACT_RD_DB: rd_sel = rd_db;
      default:   rd_sel = 32'sd0;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      phase     <= PH_FWD;
      cnt       <= '0;
      x         <= '0;
      y         <= '0;
      z         <= '0;
      act       <= ACT_WR_A;
      err_q     <= 1'b0;
      rsp_valid <= 1'b0;
      rsp_value <= 32'sd0;
      rsp_err   <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready && !wr_accept) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          cnt <= cnt + AW'(1);
          if (cnt_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            act   <= req_act;
            err_q <= req_err;
            x     <= '0;
            y     <= '0;
            z     <= '0;
            case (req_act)
              ACT_WR_A, ACT_WR_B, ACT_WR_G: begin
                rsp_valid <= 1'b1;
                rsp_value <= 32'sd0;
                rsp_err   <= req_err;
              end
              ACT_FWD: begin
                phase <= PH_FWD;
                state <= S_ISSUE;
              end
              ACT_BWD: begin
                phase <= PH_DA;
                state <= S_ISSUE;
              end
              default: state <= S_RD;
            endcase
          end
        end
        S_RD: begin
          rsp_valid <= 1'b1;
          rsp_value <= err_q ? 32'sd0 : rd_sel;
          rsp_err   <= err_q;
          state     <= S_IDLE;
        end
        S_ISSUE: state <= S_MUL;
        S_MUL:   state <= S_ACC;
        S_ACC: begin
          if (z_last) begin
            state <= S_WB;
          end else begin
            z     <= z + IW'(1);
            state <= S_ISSUE;
          end
        end
        S_WB: begin
          z     <= '0;
          state <= S_ISSUE;
          if (!y_last) begin
            y <= y + IW'(1);
          end else begin
            y <= '0;
            if (!x_last) begin
              x <= x + IW'(1);
            end else begin
              x <= '0;
              case (phase)
                PH_FWD: begin
                  cnt   <= '0;
                  state <= S_ZERO;
                end
                PH_DA: phase <= PH_DB;
                default: begin
                  rsp_valid <= 1'b1;
                  rsp_value <= 32'sd0;
                  rsp_err   <= 1'b0;
                  state     <= S_IDLE;
                end
              endcase
            end
          end
        end
        S_ZERO: begin
          cnt <= cnt + AW'(1);
          if (cnt_last) begin
            rsp_valid <= 1'b1;
            rsp_value <= 32'sd0;
            rsp_err   <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.read_value  = rsp_value;
  assign rsp.index_error = rsp_err;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp.valid || state != S_IDLE)
    else $error("request taken with no response or run following");
  a_err_reads_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.index_error |-> rsp.read_value == 32'sd0)
    else $error("index error with non-zero value");
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR || state == S_ZERO) |-> !req.ready)
    else $error("request taken during clearing sweep");
`endif

endmodule
